// ===== hdl/lcmpf_pkg.sv =====
// Package for the LCM by prime factor exponents block.
// Widths and constants shared by the divider, the multiplier and the top level.
// No dependencies.
package lcmpf_pkg;

    localparam int VALUE_MAX_DEF = 1023;  // largest value that is factored
    localparam int IN_VALUE_W    = 10;    // value field on the input stream
    localparam int S_TDATA_W     = 16;    // value padded to whole bytes
    localparam int LCM_W         = 64;
    localparam int M_TDATA_W     = 64;
    localparam int EXP_W         = 4;
    localparam int EXP_MAX       = 15;
    localparam int CHUNK_W       = 16;    // multiplier slice of the accumulator
    localparam int NCHUNK        = LCM_W / CHUNK_W;
    localparam int CHUNK_IDX_W   = $clog2(NCHUNK);

endpackage

// ===== hdl/lcm_by_prime_factor_exponents_top.sv =====
// Top level: sequencer, exponent table and output register of the LCM block.
// Uses lcmpf_pkg, lcmpf_div and lcmpf_mul.
// Per value: each divisor tried up to sqrt(value) runs its divisions in the shared divider,
// then a table read and a table write.
// Last item of a set adds the table walk over every entry from 2 to VALUE_MAX through the
// single table port, with a sliced multiply per power of each prime factor. One item at a time.
// After reset the table is swept to zero with s_tready low.
module lcm_by_prime_factor_exponents_top #(
    parameter int VALUE_MAX = lcmpf_pkg::VALUE_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lcmpf_pkg::S_TDATA_W-1:0] s_tdata,   // [9:0] value, rest zero
    input  logic                            s_tlast,   // last value of the set
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lcmpf_pkg::M_TDATA_W-1:0] m_tdata,   // [63:0] lcm
    output logic                            m_tuser    // [0] overflow
);
    import lcmpf_pkg::*;

    localparam int VW    = $clog2(VALUE_MAX + 1);
    localparam int DEPTH = VALUE_MAX + 1;
    localparam int SQW   = 2 * VW + 2;
    localparam int XW    = 17;   // holds any input value and VALUE_MAX

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_TBL_RD,
        ST_TBL_WR,
        ST_P_READ,
        ST_P_EVAL,
        ST_P_MUL,
        ST_OUT
    } state_t;

    state_t           state_reg;
    logic [VW-1:0]    clr_reg;
    logic [VW-1:0]    w_reg;
    logic [VW-1:0]    d_reg;
    logic [SQW-1:0]   sq_reg;
    logic [EXP_W-1:0] cnt_reg;
    logic             last_reg;
    logic [VW-1:0]    p_reg;
    logic [EXP_W-1:0] e_reg;
    logic [LCM_W-1:0] acc_reg;
    logic             over_reg;
    logic             div_start_reg;
    logic             mul_start_reg;
    logic             m_tvalid_reg;
    logic [LCM_W-1:0] lcm_out_reg;
    logic             ovf_out_reg;

    logic [EXP_W-1:0] exp_mem [DEPTH];
    logic [EXP_W-1:0] exp_rd_reg;
    logic [VW-1:0]    mem_addr;
    logic             mem_we;
    logic [EXP_W-1:0] mem_wdata;

    logic [XW-1:0]    in_ext;
    logic [VW-1:0]    in_value;
    logic [SQW-1:0]   sq_next;
    logic [VW-1:0]    d_next;
    logic             div_done;
    logic [VW-1:0]    div_quo;
    logic             div_rem_zero;
    logic             mul_done;
    logic [LCM_W-1:0] mul_result;
    logic             mul_over;

    assign in_ext   = XW'(s_tdata[IN_VALUE_W-1:0]);
    assign in_value = (in_ext > XW'(VALUE_MAX)) ? VW'(VALUE_MAX) : VW'(in_ext);
    // (d+1)^2 from d^2
    assign sq_next  = sq_reg + SQW'({d_reg, 1'b1});
    assign d_next   = d_reg + 1'b1;

    lcmpf_div #(.VW(VW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (w_reg),
        .divisor  (d_reg),
        .done     (div_done),
        .quotient (div_quo),
        .rem_zero (div_rem_zero)
    );

    lcmpf_mul #(.VW(VW)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start_reg),
        .acc    (acc_reg),
        .prime  (p_reg),
        .done   (mul_done),
        .result (mul_result),
        .over   (mul_over)
    );

    always_comb
    begin
        mem_addr  = d_reg;
        mem_we    = 1'b0;
        mem_wdata = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_addr = clr_reg;
                mem_we   = 1'b1;
            end
            ST_TBL_WR:
            begin
                mem_we    = (cnt_reg > exp_rd_reg);
                mem_wdata = cnt_reg;
            end
            // walk reads each entry and clears it for the next set
            ST_P_READ:
            begin
                mem_addr = p_reg;
                mem_we   = 1'b1;
            end
            default:
            begin
                mem_addr = d_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            exp_mem[mem_addr] <= mem_wdata;
        exp_rd_reg <= exp_mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            w_reg         <= '0;
            d_reg         <= VW'(2);
            sq_reg        <= SQW'(4);
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            p_reg         <= VW'(2);
            e_reg         <= '0;
            acc_reg       <= LCM_W'(1);
            over_reg      <= 1'b0;
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            lcm_out_reg   <= '0;
            ovf_out_reg   <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT))
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == VW'(VALUE_MAX))
                        state_reg <= ST_IDLE;
                end

                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        w_reg    <= in_value;
                        last_reg <= s_tlast;
                        cnt_reg  <= '0;
                        sq_reg   <= SQW'(4);
                        if (in_value <= VW'(1))
                        begin
                            if (s_tlast)
                            begin
                                p_reg     <= VW'(2);
                                acc_reg   <= LCM_W'(1);
                                over_reg  <= 1'b0;
                                state_reg <= ST_P_READ;
                            end
                        end
                        else
                        begin
                            // 2 and 3 are their own first divisor
                            d_reg         <= (SQW'(in_value) < SQW'(4)) ? in_value : VW'(2);
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_DIV;
                        end
                    end
                end

                ST_DIV:
                begin
                    if (div_done)
                    begin
                        if (div_rem_zero)
                        begin
                            w_reg         <= div_quo;
                            if (cnt_reg != EXP_W'(EXP_MAX))
                                cnt_reg <= cnt_reg + 1'b1;
                            div_start_reg <= 1'b1;
                        end
                        else
                            state_reg <= ST_TBL_RD;
                    end
                end

                ST_TBL_RD:
                begin
                    state_reg <= ST_TBL_WR;
                end

                ST_TBL_WR:
                begin
                    cnt_reg <= '0;
                    if (w_reg <= VW'(1))
                    begin
                        if (last_reg)
                        begin
                            p_reg     <= VW'(2);
                            acc_reg   <= LCM_W'(1);
                            over_reg  <= 1'b0;
                            state_reg <= ST_P_READ;
                        end
                        else
                        begin
                            d_reg     <= VW'(2);
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        // no divisor left below the square root: the rest is prime
                        if (sq_next > SQW'(w_reg))
                            d_reg <= w_reg;
                        else
                        begin
                            d_reg  <= d_next;
                            sq_reg <= sq_next;
                        end
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV;
                    end
                end

                ST_P_READ:
                begin
                    state_reg <= ST_P_EVAL;
                end

                ST_P_EVAL:
                begin
                    if ((exp_rd_reg == '0) || over_reg)
                    begin
                        if (p_reg == VW'(VALUE_MAX))
                            state_reg <= ST_OUT;
                        else
                        begin
                            p_reg     <= p_reg + 1'b1;
                            state_reg <= ST_P_READ;
                        end
                    end
                    else
                    begin
                        e_reg         <= exp_rd_reg - 1'b1;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_P_MUL;
                    end
                end

                ST_P_MUL:
                begin
                    if (mul_done)
                    begin
                        if (mul_over)
                        begin
                            over_reg <= 1'b1;
                            acc_reg  <= '1;
                        end
                        else
                            acc_reg <= mul_result;

                        if ((e_reg == '0) || mul_over)
                        begin
                            if (p_reg == VW'(VALUE_MAX))
                                state_reg <= ST_OUT;
                            else
                            begin
                                p_reg     <= p_reg + 1'b1;
                                state_reg <= ST_P_READ;
                            end
                        end
                        else
                        begin
                            e_reg         <= e_reg - 1'b1;
                            mul_start_reg <= 1'b1;
                        end
                    end
                end

                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        lcm_out_reg  <= acc_reg;
                        ovf_out_reg  <= over_reg;
                        w_reg        <= '0;
                        d_reg        <= VW'(2);
                        acc_reg      <= LCM_W'(1);
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = lcm_out_reg;
    assign m_tuser  = ovf_out_reg;

endmodule

// ===== hdl/lcmpf_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Gives the quotient and whether the remainder is zero. Uses lcmpf_pkg.
module lcmpf_div #(
    parameter int VW = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [VW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [VW-1:0] quotient,
    output logic          rem_zero
);
    import lcmpf_pkg::*;

    localparam int CW = (VW > 1) ? $clog2(VW) : 1;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] step_reg;
    logic [VW:0]   rem_reg;
    logic [VW-1:0] quo_reg;

    logic [VW:0]   trial;
    logic          fits;

    // remainder shifted left with the next dividend bit brought in
    assign trial = {rem_reg[VW-1:0], quo_reg[VW-1]};
    assign fits  = (trial >= (VW+1)'(divisor));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == CW'(VW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (trial - (VW+1)'(divisor)) : trial;
            quo_reg <= {quo_reg[VW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_zero = (rem_reg == '0);

endmodule

// ===== hdl/lcmpf_mul.sv =====
// Multiplies the 64-bit running product by a prime, one 16-bit slice a cycle.
// Flags a product that does not fit in 64 bits. Uses lcmpf_pkg.
module lcmpf_mul #(
    parameter int VW = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lcmpf_pkg::LCM_W-1:0] acc,
    input  logic [VW-1:0]               prime,
    output logic                        done,
    output logic [lcmpf_pkg::LCM_W-1:0] result,
    output logic                        over
);
    import lcmpf_pkg::*;

    localparam int PRW = LCM_W + VW;

    logic                   busy_reg;
    logic                   done_reg;
    logic [CHUNK_IDX_W-1:0] k_reg;
    logic [PRW-1:0]         prod_reg;

    logic [CHUNK_W+VW-1:0]  partial;

    // Horner over slices, top slice first; the true value never passes PRW bits
    assign partial = acc[k_reg*CHUNK_W +: CHUNK_W] * prime;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= CHUNK_IDX_W'(NCHUNK - 1);
            end
            else if (busy_reg)
            begin
                if (k_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                k_reg <= k_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            prod_reg <= '0;
        else if (busy_reg)
            prod_reg <= {prod_reg[PRW-CHUNK_W-1:0], CHUNK_W'(0)} + PRW'(partial);
    end

    assign done   = done_reg;
    assign result = prod_reg[LCM_W-1:0];
    assign over   = |prod_reg[PRW-1:LCM_W];

endmodule
